>>> sv/mctmf_pkg.sv
// Package: widths, microcode word layout and control program of the trimmed-mean filter.
package mctmf_pkg;

   localparam int WINDOW           = 12;
   localparam int TRIM             = 2;
   localparam int KEEP             = WINDOW - 2 * TRIM;
   localparam int MEAN_SHIFT       = 3;
   localparam int SAMPLE_W         = 12;
   localparam int FILT_W           = 12;
   localparam int CHAN_W           = 2;
   localparam int REQ_TDATA_W      = 16;
   localparam int REQ_TUSER_W      = 3;
   localparam int RSP_TDATA_W      = 16;
   localparam int RSP_TUSER_W      = 2;
   localparam int DEF_SAMPLE_BITS  = 12;
   localparam int DEF_CHANNELS     = 4;
   localparam int PC_W             = 4;
   localparam int CNT_W            = 4;

   typedef logic [PC_W-1:0]  pc_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CLEAR,
      COND_BAD_CHAN,
      COND_CNT_NE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     acc_clr;
      logic     cnt_clr;
      logic     cnt_inc;
      logic     wr;
      logic     rd;
      logic     srt;
      logic     sum;
      logic     load;
      logic     clr;
      cond_type cond;
      cnt_type  limit;
      pc_type   target;
   } uword_type;

   localparam pc_type ST_WAIT   = 4'd0;
   localparam pc_type ST_DISP   = 4'd1;
   localparam pc_type ST_CHK    = 4'd2;
   localparam pc_type ST_WRITE  = 4'd3;
   localparam pc_type ST_READ   = 4'd4;
   localparam pc_type ST_DRAIN  = 4'd5;
   localparam pc_type ST_SORT   = 4'd6;
   localparam pc_type ST_SUMSET = 4'd7;
   localparam pc_type ST_SUM    = 4'd8;
   localparam pc_type ST_OUT    = 4'd9;
   localparam pc_type ST_DONE   = 4'd10;
   localparam pc_type ST_CLR    = 4'd11;

   localparam cnt_type LAST_ENTRY = CNT_W'(WINDOW - 1);
   localparam cnt_type LAST_PASS  = CNT_W'(WINDOW - 1);
   localparam cnt_type LAST_KEEP  = CNT_W'(KEEP - 1);

   // taken jump goes to target, otherwise pc + 1
   function automatic uword_type uc_rom(input pc_type pc);
      uword_type w;
      w        = '0;
      w.cond   = COND_ALWAYS;
      w.target = ST_WAIT;
      case (pc)
         ST_WAIT: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = ST_WAIT;
         end
         ST_DISP: begin
            w.acc_clr = 1'b1;
            w.cnt_clr = 1'b1;
            w.cond    = COND_CLEAR;
            w.target  = ST_CLR;
         end
         ST_CHK: begin
            w.cond   = COND_BAD_CHAN;
            w.target = ST_OUT;
         end
         ST_WRITE: begin
            w.wr     = 1'b1;
            w.cond   = COND_CNT_NE;
            w.limit  = '0;
            w.target = ST_WAIT;
         end
         ST_READ: begin
            w.rd      = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = COND_CNT_NE;
            w.limit   = LAST_ENTRY;
            w.target  = ST_READ;
         end
         ST_DRAIN: begin
            w.cnt_clr = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = ST_SORT;
         end
         ST_SORT: begin
            w.srt     = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = COND_CNT_NE;
            w.limit   = LAST_PASS;
            w.target  = ST_SORT;
         end
         ST_SUMSET: begin
            w.cnt_clr = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = ST_SUM;
         end
         ST_SUM: begin
            w.sum     = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = COND_CNT_NE;
            w.limit   = LAST_KEEP;
            w.target  = ST_SUM;
         end
         ST_OUT: begin
            w.load   = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = ST_OUT;
         end
         ST_DONE: begin
            w.cond   = COND_ALWAYS;
            w.target = ST_WAIT;
         end
         ST_CLR: begin
            w.clr    = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = ST_OUT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/multichannel_trimmed_mean_filter.sv
// Top level: four-channel ring windows with a microcoded sort and trimmed-mean datapath.
//
//  channel | dir | tdata                       | tuser
//  req_    | in  | [11:0] sample               | [1:0] chan, [2] clear_all
//  rsp_    | out | [11:0] filtered            | [1:0] out_chan
//
// After accept the control program sequences 12 memory reads, 12 odd-even sort passes and
// 8 accumulate steps, one per cycle, then loads the result and returns to take the next word.
// A clear word or a sample for a missing channel skips the window steps and loads its result
// at the output step; a result register still held by the receiver stalls the program at the
// output step.
// One word is in work at a time; the next is taken while the result register still waits.
// Reset (synchronous) clears the valid bits of the window memory and all write slots.
module multichannel_trimmed_mean_filter
   import mctmf_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int CHANNELS    = DEF_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [11:0] sample, rest zero
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [1:0] chan, [2] clear_all
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [11:0] filtered, rest zero
   output logic [RSP_TUSER_W-1:0] rsp_tuser    // [1:0] out_chan
);

   localparam int STORE_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int ACC_W    = STORE_W + $clog2(KEEP);
   localparam int DEPTH    = CHANNELS * WINDOW;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W   = $clog2(WINDOW);

   typedef logic [STORE_W-1:0] smp_type;
   typedef logic [SLOT_W-1:0]  slot_type;

   uword_type uw;
   pc_type    pc_ff, pc_in;
   cnt_type   cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic [CHAN_W-1:0] item_chan_ff;
   smp_type           item_sample_ff;
   logic              item_clr_ff;

   slot_type          slot_ff [CHANNELS];
   slot_type          slot_in [CHANNELS];
   logic [DEPTH-1:0]  valid_ff, valid_in;
   smp_type           win_mem [DEPTH];

   smp_type           rd_data_ff;
   logic              rd_vld_ff;
   logic              rd_pend_ff;
   slot_type          rd_idx_ff;

   smp_type           buf_ff [WINDOW];
   smp_type           buf_in [WINDOW];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [FILT_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic [CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;

   logic                accept;
   logic                bad_chan;
   logic                busy;
   logic                cond_hit;
   logic [CH_IDX_W-1:0] chan_idx;
   slot_type            cur_slot;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;

   assign uw         = uc_rom(pc_ff);
   assign req_tready = uw.accept;
   assign accept     = req_tvalid & req_tready;
   assign bad_chan   = int'(item_chan_ff) >= CHANNELS;
   assign busy       = rsp_valid_ff & ~rsp_tready;
   assign chan_idx   = CH_IDX_W'(item_chan_ff);
   assign cur_slot   = slot_ff[chan_idx];
   assign wr_addr    = ADDR_W'(int'(chan_idx) * WINDOW + int'(cur_slot));
   assign rd_addr    = ADDR_W'(int'(chan_idx) * WINDOW + int'(cnt_ff[SLOT_W-1:0]));

   always_comb begin
      case (uw.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_NO_REQ:   cond_hit = ~req_tvalid;
         COND_CLEAR:    cond_hit = item_clr_ff;
         COND_BAD_CHAN: cond_hit = bad_chan;
         COND_CNT_NE:   cond_hit = cnt_ff != uw.limit;
         COND_OUT_BUSY: cond_hit = busy;
         default:       cond_hit = 1'b1;
      endcase
      pc_in = cond_hit ? uw.target : pc_ff + pc_type'(1);
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (uw.cnt_clr) begin
         cnt_in = '0;
      end else if (uw.cnt_inc) begin
         cnt_in = cnt_ff + cnt_type'(1);
      end
      acc_in = acc_ff;
      if (uw.acc_clr) begin
         acc_in = '0;
      end else if (uw.sum) begin
         acc_in = acc_ff + ACC_W'(buf_ff[SLOT_W'(cnt_ff + cnt_type'(TRIM))]);
      end
   end

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (uw.clr) begin
         for (int c = 0; c < CHANNELS; c++) begin
            slot_in[c] = '0;
         end
         valid_in = '0;
      end else if (uw.wr) begin
         slot_in[chan_idx] = (cur_slot == slot_type'(WINDOW - 1)) ? '0
                                                                 : cur_slot + slot_type'(1);
         valid_in[wr_addr] = 1'b1;
      end
   end

   // odd-even transposition: even pass on even cnt, odd pass on odd cnt
   always_comb begin
      buf_in = buf_ff;
      if (rd_pend_ff) begin
         buf_in[rd_idx_ff] = rd_vld_ff ? rd_data_ff : '0;
      end
      if (uw.srt) begin
         for (int i = 0; i + 1 < WINDOW; i++) begin
            if ((i[0] == cnt_ff[0]) && (buf_ff[i] > buf_ff[i+1])) begin
               buf_in[i]   = buf_ff[i+1];
               buf_in[i+1] = buf_ff[i];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_filt_in  = rsp_filt_ff;
      rsp_chan_in  = rsp_chan_ff;
      if (uw.load && !busy) begin
         rsp_valid_in = 1'b1;
         rsp_filt_in  = FILT_W'(acc_ff >> MEAN_SHIFT);
         rsp_chan_in  = item_chan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_WAIT;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            slot_ff[c] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rd_pend_ff   <= uw.rd;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      buf_ff      <= buf_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_chan_ff <= rsp_chan_in;
      rd_idx_ff   <= cnt_ff[SLOT_W-1:0];
      if (accept) begin
         item_chan_ff   <= req_tuser[CHAN_W-1:0];
         item_sample_ff <= req_tdata[STORE_W-1:0];
         item_clr_ff    <= req_tuser[CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (uw.wr) begin
         win_mem[wr_addr] <= item_sample_ff;
      end
      rd_data_ff <= win_mem[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_filt_ff);
   assign rsp_tuser  = rsp_chan_ff;

`ifndef SYNTHESIS
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= ST_CLR)
      else $error("control program counter out of range");

   a_load_at_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pc_ff) == ST_OUT)
      else $error("result loaded outside the output step");
`endif

endmodule

>>> bench/multichannel_trimmed_mean_filter_test.sv
// Self-checking bench for the four-channel trimmed-mean filter: streamed samples, scoreboard.
`timescale 1ns / 1ps

module multichannel_trimmed_mean_filter_test
   import mctmf_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_WORDS = 900;

   typedef struct {
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
      logic                clear_all;
   } adc_word_type;

   typedef struct {
      logic [FILT_W-1:0] filtered;
      logic [CHAN_W-1:0] chan;
   } filter_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   adc_word_type      pending_words[$];
   filter_result_type expected_results[$];

   logic [SAMPLE_W-1:0] window_model[DEF_CHANNELS][WINDOW];
   int                  slot_model[DEF_CHANNELS];

   int errors       = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   multichannel_trimmed_mean_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_pct(input int n);
      return (n >= 400 && n < 550) ? 0 : 20;
   endfunction

   function automatic void clear_windows();
      for (int c = 0; c < DEF_CHANNELS; c++) begin
         slot_model[c] = 0;
         for (int k = 0; k < WINDOW; k++)
            window_model[c][k] = '0;
      end
   endfunction

   function automatic logic [FILT_W-1:0] trimmed_mean(input int ch);
      logic [SAMPLE_W-1:0] sorted[WINDOW];
      logic [SAMPLE_W-1:0] v;
      int j;
      int total;
      total = 0;
      for (int i = 0; i < WINDOW; i++)
         sorted[i] = window_model[ch][i];
      for (int i = 1; i < WINDOW; i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = v;
      end
      for (int i = TRIM; i < WINDOW - TRIM; i++)
         total += sorted[i];
      return FILT_W'(total >> MEAN_SHIFT);
   endfunction

   function automatic void filter_predict(input logic [CHAN_W-1:0] ch,
                                          input logic [SAMPLE_W-1:0] smp,
                                          input logic clr);
      filter_result_type r;
      r.chan = ch;
      if (clr) begin
         clear_windows();
         r.filtered = '0;
      end else if (int'(ch) >= DEF_CHANNELS) begin
         r.filtered = '0;
      end else begin
         window_model[ch][slot_model[ch]] = smp;
         slot_model[ch] = (slot_model[ch] + 1) % WINDOW;
         r.filtered = trimmed_mean(ch);
      end
      expected_results.push_back(r);
   endfunction

   function automatic void add_word(input int ch, input int smp, input bit clr);
      adc_word_type w;
      w.chan      = CHAN_W'(ch);
      w.sample    = SAMPLE_W'(smp);
      w.clear_all = clr;
      pending_words.push_back(w);
   endfunction

   // driver
   always @(posedge clock) begin : drive
      adc_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            filter_predict(req_tuser[CHAN_W-1:0], req_tdata[SAMPLE_W-1:0], req_tuser[2]);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct(words_sent)) begin
               nxt = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'(nxt.sample);
               req_tuser  <= {nxt.clear_all, nxt.chan};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      filter_result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected word expected none actual filtered %0d chan %0d",
                        $time, rsp_tdata[FILT_W-1:0], rsp_tuser[CHAN_W-1:0]);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tdata[FILT_W-1:0] !== exp_r.filtered) begin
                  errors++;
                  $display("%0t: filtered mismatch expected %0d actual %0d", $time,
                           exp_r.filtered, rsp_tdata[FILT_W-1:0]);
               end
               if (rsp_tuser[CHAN_W-1:0] !== exp_r.chan) begin
                  errors++;
                  $display("%0t: out_chan mismatch expected %0d actual %0d", $time,
                           exp_r.chan, rsp_tuser[CHAN_W-1:0]);
               end
            end
            if (results_seen == 100)
               stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct(results_seen));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int smp;
      int total_words;
      clear_windows();

      add_word(0, 0, 1'b1);
      add_word(0, 4095, 1'b0);
      add_word(1, 0, 1'b0);
      add_word(2, 4095, 1'b0);
      add_word(3, 12'hAAA, 1'b0);
      add_word(3, 12'h555, 1'b0);
      // wrap channel 0 past a full window
      for (int i = 0; i < 12; i++)
         add_word(0, (i % 3 == 0) ? 0 : (i % 3 == 1) ? 4095 : i * 300, 1'b0);
      add_word(3, 4095, 1'b1);
      add_word(2, 7, 1'b0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         r = $urandom_range(99);
         case ($urandom_range(7))
            0:       smp = 0;
            1:       smp = 4095;
            default: smp = $urandom_range(4095);
         endcase
         add_word($urandom_range(3), smp, r < 2);
      end
      total_words = pending_words.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (results_seen < total_words)
         @(posedge clock);
      repeat (60) @(posedge clock);

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> multichannel_trimmed_mean_filter.f
sv/mctmf_pkg.sv
sv/multichannel_trimmed_mean_filter.sv
bench/multichannel_trimmed_mean_filter_test.sv
